// ===== design/alpha_blend_rgba_opacity_top_assert.svh =====
// Assertion macros for the alpha blend block.
// Used by alpha_blend_rgba_opacity_top; expects clk and rst_n in scope.
`ifndef ALPHA_BLEND_RGBA_OPACITY_TOP_ASSERT_SVH
`define ALPHA_BLEND_RGBA_OPACITY_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ABRO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ABRO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/abro_pkg.sv =====
// Shared types, register map and the divide-by-255 helper for the alpha blend.
// No dependencies.
package abro_pkg;

  typedef struct packed {
    logic [31:0] dst_pixel;
    logic [31:0] overlay_pixel;
    logic [7:0]  mask_value;
    logic        row_end;
    logic        frame_end;
  } abro_in_t;

  typedef struct packed {
    logic [31:0] blended_pixel;
    logic        row_end_out;
    logic        frame_end_out;
  } abro_out_t;

  typedef struct packed {
    logic [7:0] opacity;
    logic       alpha_from_mask;
  } abro_cfg_t;

  localparam int unsigned AddrW = 3;
  // register index is address bit 2
  localparam logic RegOpacity       = 1'b0;
  localparam logic RegAlphaFromMask = 1'b1;

  localparam logic [7:0]  OpacityReset = 8'd255;
  localparam logic [7:0]  ChanMax      = 8'd255;
  localparam logic [15:0] RoundBias    = 16'd127;

  // floor(x/255) for x below 65280 (quotient fits 8 bits, 16-bit sum does not wrap):
  // (x + 1 + x/256) / 256
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] t;
    t = x + 16'd1 + {8'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

// ===== design/abro_regs.sv =====
// APB-style configuration registers: opacity and alpha source select.
// Depends on abro_pkg.
module abro_regs import abro_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output abro_cfg_t        cfg
);

  logic [7:0] opacity_r, opacity_nxt;
  logic       from_mask_r, from_mask_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    opacity_nxt   = opacity_r;
    from_mask_nxt = from_mask_r;
    if (wr_en) begin
      unique case (paddr[2])
        RegOpacity:       opacity_nxt   = pwdata[7:0];
        RegAlphaFromMask: from_mask_nxt = pwdata[0];
        default:          opacity_nxt   = opacity_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opacity_r   <= OpacityReset;
      from_mask_r <= 1'b0;
    end else begin
      opacity_r   <= opacity_nxt;
      from_mask_r <= from_mask_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegOpacity:       prdata = {24'd0, opacity_r};
      RegAlphaFromMask: prdata = {31'd0, from_mask_r};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg.opacity         = opacity_r;
  assign cfg.alpha_from_mask = from_mask_r;

endmodule

// ===== design/alpha_blend_rgba_opacity_top.sv =====
// Alpha blend of a BGRA overlay pixel onto a destination pixel, with global opacity.
// Depends on abro_pkg, abro_regs and alpha_blend_rgba_opacity_top_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries destination pixel, overlay
//   pixel, mask byte and row/frame end flags. Output channel (out_valid/out_ready/
//   out_data) returns one blended pixel per input, in order, flags passed along.
//   The APB-style port writes opacity (0x0) and alpha source select (0x4);
//   write only while no pixel is in flight.
// Timing:
//   Four register stages: alpha*opacity, effective alpha (divide by 255),
//   per-channel weighted sums (two 8x8 multiplies per lane), final divide.
//   One pixel per cycle sustained while the receiver holds out_ready high;
//   the multiply stages set the stage depth.
// Reset and stall:
//   Reset empties the pipeline and loads opacity 255, alpha from overlay byte 3.
//   When the receiver stalls, the output stage holds; earlier stages keep
//   filling bubbles, and in_ready drops only once every stage is occupied.
module alpha_blend_rgba_opacity_top import abro_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  abro_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output abro_out_t        out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  abro_cfg_t cfg;

  abro_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage valids and advance enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // stage 1: alpha * opacity + bias
  logic [7:0]  alpha_sel;
  logic [15:0] s1_prod_nxt;
  logic [15:0] s1_prod_r;
  logic [31:0] s1_dst_r, s1_ovr_r;
  logic        s1_row_r, s1_frame_r;

  assign alpha_sel   = cfg.alpha_from_mask ? in_data.mask_value : in_data.overlay_pixel[31:24];
  assign s1_prod_nxt = alpha_sel * cfg.opacity + RoundBias;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_prod_r  <= s1_prod_nxt;
      s1_dst_r   <= in_data.dst_pixel;
      s1_ovr_r   <= in_data.overlay_pixel;
      s1_row_r   <= in_data.row_end;
      s1_frame_r <= in_data.frame_end;
    end
  end

  // stage 2: effective alpha and its complement
  logic [7:0]  s2_aeff_r, s2_inv_r;
  logic [31:0] s2_dst_r, s2_ovr_r;
  logic        s2_row_r, s2_frame_r;
  logic [7:0]  aeff_nxt;

  assign aeff_nxt = div255(s1_prod_r);

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_aeff_r  <= aeff_nxt;
      s2_inv_r   <= ChanMax - aeff_nxt;
      s2_dst_r   <= s1_dst_r;
      s2_ovr_r   <= s1_ovr_r;
      s2_row_r   <= s1_row_r;
      s2_frame_r <= s1_frame_r;
    end
  end

  // stage 3: per-lane dst*inv + ovr*aeff + bias, stage 4: divide by 255
  logic [3:0][15:0] s3_sum_nxt, s3_sum_r;
  logic [3:0][7:0]  s4_chan_nxt;
  logic             s3_row_r, s3_frame_r;
  abro_out_t        s4_out_r;

  for (genvar ch = 0; ch < 4; ch++) begin : g_lane
    logic [15:0] dprod, oprod;
    assign dprod = s2_dst_r[8*ch +: 8] * s2_inv_r;
    assign oprod = s2_ovr_r[8*ch +: 8] * s2_aeff_r;
    // max 255*255 + 127, fits 16 bits
    assign s3_sum_nxt[ch]  = dprod + oprod + RoundBias;
    assign s4_chan_nxt[ch] = div255(s3_sum_r[ch]);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_sum_r   <= s3_sum_nxt;
      s3_row_r   <= s2_row_r;
      s3_frame_r <= s2_frame_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_out_r.blended_pixel <= s4_chan_nxt;
      s4_out_r.row_end_out   <= s3_row_r;
      s4_out_r.frame_end_out <= s3_frame_r;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = s4_out_r;

`include "alpha_blend_rgba_opacity_top_assert.svh"

  `ABRO_ASSERT_NXT(a_in_lands, in_valid && in_ready, v1_r, "accepted transfer not in stage 1")
  `ABRO_ASSERT_IMP(a_full_stall, v1_r && v2_r && v3_r && v4_r && !out_ready, !in_ready,
                   "input accepted while pipeline full and stalled")
  `ABRO_ASSERT_NXT(a_out_hold, v4_r && !out_ready, v4_r && $stable(s4_out_r),
                   "stalled output stage changed")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for alpha_blend_rgba_opacity_top: directed pixel table, then random
// pixel phases under several opacity / alpha-source settings, with random idling on both sides.
// Depends on abro_pkg and the RTL of alpha_blend_rgba_opacity_top.
module tb_top;
  import abro_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int IDLE_PCT       = 11;
  localparam int DRAIN_CYCLES   = 8;       // pipeline is 4 deep
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int HOLD_AT        = 250;     // result count that triggers the long stall
  localparam int HOLD_CYCLES    = 80;
  localparam int MAX_REPORTS    = 10;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 175;
  localparam int CALM_PHASE     = 2;       // phase run with no idling on either side
  localparam int unsigned CHAN_FULL  = 255;
  localparam int unsigned ROUND_HALF = 127;

  typedef struct packed {
    logic [7:0]  opacity;
    logic        from_mask;
    logic [31:0] dst;
    logic [31:0] ovr;
    logic [7:0]  mask;
    logic        row_end;
    logic        frame_end;
    logic        typed;       // expected pixel given below rather than predicted
    logic [31:0] blended;
  } dir_row_t;

  localparam int NUM_DIRECTED = 23;
  localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // reset settings: full opacity, alpha from overlay byte 3
    '{8'd255, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF},
    '{8'd255, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 8'hFF, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF},
    '{8'd255, 1'b0, 32'h1234_5678, 32'hFF9A_BCDE, 8'h00, 1'b0, 1'b1, 1'b1, 32'hFF9A_BCDE},
    // mask byte must be ignored here
    '{8'd255, 1'b0, 32'hA5A5_A5A5, 32'h005A_5A5A, 8'hFF, 1'b1, 1'b1, 1'b1, 32'hA5A5_A5A5},
    '{8'd255, 1'b0, 32'h0000_0000, 32'h80FF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'd255, 1'b0, 32'hFFFF_FFFF, 32'h7F00_0000, 8'h55, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'd255, 1'b0, 32'h0F0F_0F0F, 32'h01F0_F0F0, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'd255, 1'b0, 32'hF0F0_F0F0, 32'hFE0F_0F0F, 8'hAA, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'd128, 1'b0, 32'hFFFF_FFFF, 32'hFF00_0000, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'd128, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'd128, 1'b0, 32'h8080_8080, 32'h8040_4040, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
    // zero opacity passes the destination through
    '{8'd0,   1'b0, 32'h1357_9BDF, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0, 1'b1, 32'h1357_9BDF},
    '{8'd0,   1'b0, 32'hFFFF_FFFF, 32'hFF00_0000, 8'h00, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{8'd0,   1'b1, 32'h2468_ACE0, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0, 1'b1, 32'h2468_ACE0},
    // alpha from mask: overlay byte 3 no longer matters
    '{8'd255, 1'b1, 32'h0000_0000, 32'h00FF_FFFF, 8'hFF, 1'b0, 1'b0, 1'b1, 32'h00FF_FFFF},
    '{8'd255, 1'b1, 32'h89AB_CDEF, 32'hFFFF_FFFF, 8'h00, 1'b1, 1'b0, 1'b1, 32'h89AB_CDEF},
    '{8'd255, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 8'h80, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'd255, 1'b1, 32'h3C3C_3C3C, 32'hC3C3_C3C3, 8'h01, 1'b0, 1'b1, 1'b0, 32'h0},
    '{8'd1,   1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'd1,   1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 8'h80, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'd254, 1'b0, 32'h00FF_00FF, 32'hFFFF_00FF, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'd254, 1'b0, 32'h55AA_55AA, 32'hFEAA_55AA, 8'h33, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'd254, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 8'hFE, 1'b0, 1'b0, 1'b0, 32'h0}
  };

  localparam logic [7:0] PHASE_OPACITY [5] = '{8'd255, 8'd0, 8'd1, 8'd254, 8'd128};
  localparam logic       PHASE_FROM_MASK [5] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  abro_in_t         in_data;
  logic             out_valid;
  logic             out_ready;
  abro_out_t        out_data;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  abro_out_t   pending_blends [$];
  logic [7:0]  cur_opacity;
  logic        cur_from_mask;
  bit          no_idle;
  bit          hold_done;
  int          hold_left;
  int          pixels_sent;
  int          mask_pixels;
  int          blends_checked;
  int          mismatches;
  int          settings_applied;

  alpha_blend_rgba_opacity_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // floor((x + 127) / 255) done with plain integer division
  function automatic int unsigned round_div255(input int unsigned x);
    return (x + ROUND_HALF) / CHAN_FULL;
  endfunction

  function automatic abro_out_t predict_blend(input abro_in_t px, input logic [7:0] opacity,
                                              input logic from_mask);
    abro_out_t   r;
    int unsigned alpha;
    int unsigned a_eff;
    int unsigned a_inv;
    int unsigned d;
    int unsigned o;
    int          ch;
    alpha = from_mask ? px.mask_value : px.overlay_pixel[31:24];
    a_eff = round_div255(alpha * opacity);
    a_inv = CHAN_FULL - a_eff;
    for (ch = 0; ch < 4; ch++) begin
      d = px.dst_pixel[8*ch +: 8];
      o = px.overlay_pixel[8*ch +: 8];
      r.blended_pixel[8*ch +: 8] = 8'(round_div255(d * a_inv + o * a_eff));
    end
    r.row_end_out   = px.row_end;
    r.frame_end_out = px.frame_end;
    return r;
  endfunction

  // byte with a bias toward 0x00 and 0xFF
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic abro_in_t rand_pixel();
    abro_in_t px;
    int       b;
    for (b = 0; b < 4; b++) begin
      px.dst_pixel[8*b +: 8]     = rand_byte();
      px.overlay_pixel[8*b +: 8] = rand_byte();
    end
    px.mask_value = rand_byte();
    px.row_end    = ($urandom_range(15) == 0);
    px.frame_end  = ($urandom_range(63) == 0);
    return px;
  endfunction

  task automatic check_blend(input abro_out_t got);
    abro_out_t want;
    if (pending_blends.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("ERROR: unexpected result %h at %0t", got, $realtime);
    end else begin
      want = pending_blends.pop_front();
      if (got.blended_pixel !== want.blended_pixel || got.row_end_out !== want.row_end_out ||
          got.frame_end_out !== want.frame_end_out) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result %0d: pixel %h row %b frame %b, expected %h row %b frame %b",
                   blends_checked, got.blended_pixel, got.row_end_out, got.frame_end_out,
                   want.blended_pixel, want.row_end_out, want.frame_end_out);
      end
    end
    blends_checked++;
  endtask

  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // upper write-data bits are junk; only the register's own bits should stick
  task automatic apply_settings(input logic [7:0] opacity, input logic from_mask);
    write_reg(RegOpacity, ($urandom() & 32'hFFFF_FF00) | 32'(opacity));
    write_reg(RegAlphaFromMask, ($urandom() & 32'hFFFF_FFFE) | 32'(from_mask));
    cur_opacity   = opacity;
    cur_from_mask = from_mask;
    settings_applied++;
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_blends.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(input abro_in_t px, input logic typed, input logic [31:0] typed_px);
    abro_out_t want;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = predict_blend(px, cur_opacity, cur_from_mask);
    if (typed) want.blended_pixel = typed_px;
    pending_blends.push_back(want);
    pixels_sent++;
    if (cur_from_mask) mask_pixels++;
  endtask

  // result side: random backpressure plus one long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_blend(out_data);
      if (!hold_done && blends_checked >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("ERROR: timeout with %0d results outstanding", pending_blends.size());
    $display("alpha_blend_rgba_opacity_top regression: fail");
    $finish;
  end

  initial begin
    abro_in_t px;
    int       i;
    int       p;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    cur_opacity   = OpacityReset;
    cur_from_mask = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED_ROWS[i].opacity != cur_opacity ||
          DIRECTED_ROWS[i].from_mask != cur_from_mask) begin
        quiesce();
        apply_settings(DIRECTED_ROWS[i].opacity, DIRECTED_ROWS[i].from_mask);
      end
      px.dst_pixel     = DIRECTED_ROWS[i].dst;
      px.overlay_pixel = DIRECTED_ROWS[i].ovr;
      px.mask_value    = DIRECTED_ROWS[i].mask;
      px.row_end       = DIRECTED_ROWS[i].row_end;
      px.frame_end     = DIRECTED_ROWS[i].frame_end;
      send_pixel(px, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].blended);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      quiesce();
      if (p < 5) apply_settings(PHASE_OPACITY[p], PHASE_FROM_MASK[p]);
      else apply_settings(8'($urandom_range(255)), 1'($urandom_range(1)));
      no_idle = (p == CALM_PHASE);
      for (i = 0; i < PHASE_ITEMS; i++) send_pixel(rand_pixel(), 1'b0, 32'h0);
    end
    no_idle = 1'b0;
    quiesce();

    $display("Blended %0d pixels (%0d with mask alpha) over %0d opacity/alpha-source settings,",
             pixels_sent, mask_pixels, settings_applied);
    $display("including a %0d-cycle output hold-off; %0d results checked, %0d mismatches.",
             HOLD_CYCLES, blends_checked, mismatches);
    if (mismatches == 0) begin
      $display("alpha_blend_rgba_opacity_top regression: pass");
    end else begin
      $display("alpha_blend_rgba_opacity_top regression: fail");
    end
    $finish;
  end

endmodule
